[rtl/vtsi_pkg.sv]
// ---------------------------------------------------------------------------
// vtsi_pkg
// Shared types and codes for the interface adapter timer, shift and
// interrupt core.
// ---------------------------------------------------------------------------
package vtsi_pkg;

  // Transaction kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Register map
  localparam logic [3:0] REG_ORB   = 4'h0;
  localparam logic [3:0] REG_ORA   = 4'h1;
  localparam logic [3:0] REG_DDRB  = 4'h2;
  localparam logic [3:0] REG_DDRA  = 4'h3;
  localparam logic [3:0] REG_T1CL  = 4'h4;
  localparam logic [3:0] REG_T1CH  = 4'h5;
  localparam logic [3:0] REG_T1LL  = 4'h6;
  localparam logic [3:0] REG_T1LH  = 4'h7;
  localparam logic [3:0] REG_T2CL  = 4'h8;
  localparam logic [3:0] REG_T2CH  = 4'h9;
  localparam logic [3:0] REG_SR    = 4'ha;
  localparam logic [3:0] REG_ACR   = 4'hb;
  localparam logic [3:0] REG_PCR   = 4'hc;
  localparam logic [3:0] REG_IFR   = 4'hd;
  localparam logic [3:0] REG_IER   = 4'he;
  localparam logic [3:0] REG_ORA_NH = 4'hf;

  // Interrupt flag bit positions
  localparam int IFR_T1 = 6;
  localparam int IFR_T2 = 5;
  localparam int IFR_SR = 2;

  // Shift register modes, ACR bits 4:2
  localparam logic [2:0] SR_IN_T2   = 3'b001;
  localparam logic [2:0] SR_IN_PHI2 = 3'b010;
  localparam logic [2:0] SR_OUT_FREE = 3'b100;
  localparam logic [2:0] SR_OUT_T2  = 3'b101;
  localparam logic [2:0] SR_OUT_PHI2 = 3'b110;

  // CA2 / CB2 control codes (PCR bits 3:1 and 7:5)
  localparam logic [2:0] C2_HANDSHAKE = 3'b100;
  localparam logic [2:0] C2_PULSE     = 3'b101;
  localparam logic [2:0] C2_LOW       = 3'b110;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic       compare_in;
    logic [7:0] port_a_in;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
    logic       ca2_level;
    logic       cb2_handshake;
    logic       cb2_shift_out;
    logic       pb7_timer;
  } rsp_item_t;

endpackage

[rtl/vtsi_state.sv]
// ---------------------------------------------------------------------------
// vtsi_state
// Register file, timers, shift register and interrupt logic. Applies one
// transaction per cycle while apply is high, presenting the updated result.
// ---------------------------------------------------------------------------
module vtsi_state import vtsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      apply,
  input  req_item_t item,
  output rsp_item_t result
);

  typedef struct packed {
    logic [7:0]  out_a;
    logic [7:0]  out_b;
    logic [7:0]  dir_a;
    logic [7:0]  dir_b;
    logic        t1_running;
    logic        t1_armed;
    logic [15:0] t1_count;
    logic [7:0]  t1_latch_low;
    logic [7:0]  t1_latch_high;
    logic        t1_pb7;
    logic        t2_running;
    logic        t2_armed;
    logic [15:0] t2_count;
    logic [7:0]  t2_latch_low;
    logic [7:0]  shift_reg;
    logic [3:0]  shift_bits;
    logic [7:0]  shift_divider;
    logic        shift_phase;
    logic [7:0]  aux_ctrl;
    logic [7:0]  periph_ctrl;
    logic [6:0]  int_flags;
    logic [6:0]  int_enable;
    logic        ca2_reg;
    logic        cb2_hs_reg;
    logic        cb2_sh_reg;
  } state_t;

  state_t st;
  state_t st_next;
  logic [7:0] rd;

  always_comb begin
    logic [7:0]  pa_val;
    logic [15:0] t1_dec;
    logic [15:0] t2_dec;
    logic        t2_pulse;
    logic        do_shift;
    logic        do_count;
    logic        do_out;

    st_next  = st;
    rd       = 8'h00;
    pa_val   = (st.out_b[4:3] == 2'b01) ? item.port_a_in : st.out_a;
    t1_dec   = st.t1_count - 16'd1;
    t2_dec   = st.t2_count - 16'd1;
    t2_pulse = 1'b0;
    do_shift = 1'b0;
    do_count = 1'b0;
    do_out   = 1'b0;

    case (item.kind)
      KIND_READ: begin
        case (item.reg_addr)
          REG_ORB: begin
            if (st.aux_ctrl[7]) begin
              rd = {st.t1_pb7, st.out_b[6], item.compare_in, st.out_b[4:0]};
            end else begin
              rd = {st.out_b[7:6], item.compare_in, st.out_b[4:0]};
            end
          end
          REG_ORA: begin
            if (st.periph_ctrl[3:1] == C2_HANDSHAKE) st_next.ca2_reg = 1'b0;
            rd = pa_val;
          end
          REG_ORA_NH: rd = pa_val;
          REG_DDRB:   rd = st.dir_b;
          REG_DDRA:   rd = st.dir_a;
          REG_T1CL: begin
            rd = st.t1_count[7:0];
            st_next.int_flags[IFR_T1] = 1'b0;
            st_next.t1_running = 1'b0;
            st_next.t1_armed   = 1'b0;
            st_next.t1_pb7     = 1'b1;
          end
          REG_T1CH: rd = st.t1_count[15:8];
          REG_T1LL: rd = st.t1_latch_low;
          REG_T1LH: rd = st.t1_latch_high;
          REG_T2CL: begin
            rd = st.t2_count[7:0];
            st_next.int_flags[IFR_T2] = 1'b0;
            st_next.t2_running = 1'b0;
            st_next.t2_armed   = 1'b0;
          end
          REG_T2CH: rd = st.t2_count[15:8];
          REG_SR: begin
            rd = st.shift_reg;
            st_next.int_flags[IFR_SR] = 1'b0;
            st_next.shift_bits  = 4'd0;
            st_next.shift_phase = 1'b1;
          end
          REG_ACR: rd = st.aux_ctrl;
          REG_PCR: rd = st.periph_ctrl;
          REG_IFR: rd = {|(st.int_flags & st.int_enable), st.int_flags};
          default: rd = {1'b1, st.int_enable};
        endcase
      end

      KIND_WRITE: begin
        case (item.reg_addr)
          REG_ORB: begin
            st_next.out_b = item.write_data;
            if (st.periph_ctrl[7:5] == C2_HANDSHAKE) st_next.cb2_hs_reg = 1'b0;
          end
          REG_ORA: begin
            if (st.periph_ctrl[3:1] == C2_HANDSHAKE) st_next.ca2_reg = 1'b0;
            st_next.out_a = item.write_data;
          end
          REG_ORA_NH: st_next.out_a = item.write_data;
          REG_DDRB:   st_next.dir_b = item.write_data;
          REG_DDRA:   st_next.dir_a = item.write_data;
          REG_T1CL:   st_next.t1_latch_low = item.write_data;
          REG_T1CH: begin
            st_next.t1_latch_high = item.write_data;
            st_next.t1_count = {item.write_data, st.t1_latch_low};
            st_next.int_flags[IFR_T1] = 1'b0;
            st_next.t1_running = 1'b1;
            st_next.t1_armed   = 1'b1;
            st_next.t1_pb7     = 1'b0;
          end
          REG_T1LL: st_next.t1_latch_low  = item.write_data;
          REG_T1LH: st_next.t1_latch_high = item.write_data;
          REG_T2CL: st_next.t2_latch_low  = item.write_data;
          REG_T2CH: begin
            st_next.t2_count = {item.write_data, st.t2_latch_low};
            st_next.int_flags[IFR_T2] = 1'b0;
            st_next.t2_running = 1'b1;
            st_next.t2_armed   = 1'b1;
          end
          REG_SR: begin
            st_next.shift_reg = item.write_data;
            st_next.int_flags[IFR_SR] = 1'b0;
            st_next.shift_bits  = 4'd0;
            st_next.shift_phase = 1'b1;
          end
          REG_ACR: st_next.aux_ctrl = item.write_data;
          REG_PCR: begin
            st_next.periph_ctrl = item.write_data;
            st_next.ca2_reg    = (item.write_data[3:1] != C2_LOW);
            st_next.cb2_hs_reg = (item.write_data[7:5] != C2_LOW);
          end
          REG_IFR: st_next.int_flags = st.int_flags & ~item.write_data[6:0];
          default: begin
            if (item.write_data[7]) begin
              st_next.int_enable = st.int_enable | item.write_data[6:0];
            end else begin
              st_next.int_enable = st.int_enable & ~item.write_data[6:0];
            end
          end
        endcase
      end

      KIND_TICK: begin
        // Timer 1: one-shot, or free-run with reload and PB7 toggle.
        if (st.t1_running) begin
          st_next.t1_count = t1_dec;
          if (t1_dec == 16'hffff) begin
            if (st.aux_ctrl[6]) begin
              st_next.int_flags[IFR_T1] = 1'b1;
              st_next.t1_pb7   = ~st.t1_pb7;
              st_next.t1_count = {st.t1_latch_high, st.t1_latch_low};
            end else if (st.t1_armed) begin
              st_next.int_flags[IFR_T1] = 1'b1;
              st_next.t1_pb7   = 1'b1;
              st_next.t1_armed = 1'b0;
            end
          end
        end

        // Timer 2 counts only in one-shot mode.
        if (st.t2_running && !st.aux_ctrl[5]) begin
          st_next.t2_count = t2_dec;
          if (t2_dec == 16'hffff && st.t2_armed) begin
            st_next.int_flags[IFR_T2] = 1'b1;
            st_next.t2_armed = 1'b0;
          end
        end

        // The shift clock divider pulses on every second underflow.
        if (st.shift_divider == 8'd0) begin
          st_next.shift_divider = st.t2_latch_low;
          t2_pulse = st.shift_phase;
          st_next.shift_phase = ~st.shift_phase;
        end else begin
          st_next.shift_divider = st.shift_divider - 8'd1;
        end

        if (st.shift_bits < 4'd8) begin
          case (st.aux_ctrl[4:2])
            SR_IN_T2: begin
              do_shift = t2_pulse;
              do_count = t2_pulse;
            end
            SR_IN_PHI2: begin
              do_shift = 1'b1;
              do_count = 1'b1;
            end
            SR_OUT_FREE: do_out = t2_pulse;
            SR_OUT_T2: begin
              do_out   = t2_pulse;
              do_count = t2_pulse;
            end
            SR_OUT_PHI2: begin
              do_out   = 1'b1;
              do_count = 1'b1;
            end
            default: ;
          endcase
          if (do_shift) st_next.shift_reg = {st.shift_reg[6:0], 1'b0};
          if (do_out) begin
            // Shift-out recirculates the top bit and drives it onto CB2.
            st_next.cb2_sh_reg = st.shift_reg[7];
            st_next.shift_reg  = {st.shift_reg[6:0], st.shift_reg[7]};
          end
          if (do_count) begin
            st_next.shift_bits = st.shift_bits + 4'd1;
            if (st.shift_bits == 4'd7) st_next.int_flags[IFR_SR] = 1'b1;
          end
        end

        if (st.periph_ctrl[3:1] == C2_PULSE) st_next.ca2_reg    = 1'b1;
        if (st.periph_ctrl[7:5] == C2_PULSE) st_next.cb2_hs_reg = 1'b1;
      end

      default: ;
    endcase
  end

  assign result.read_data     = rd;
  assign result.irq           = |(st_next.int_flags & st_next.int_enable);
  assign result.port_a_out    = st_next.out_a;
  assign result.port_b_out    = st_next.out_b;
  assign result.ca2_level     = st_next.ca2_reg;
  assign result.cb2_handshake = st_next.cb2_hs_reg;
  assign result.cb2_shift_out = st_next.cb2_sh_reg;
  assign result.pb7_timer     = st_next.t1_pb7;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{t1_pb7: 1'b1, ca2_reg: 1'b1, cb2_hs_reg: 1'b1, shift_bits: 4'd8,
              default: '0};
    end else if (apply) begin
      st <= st_next;
    end
  end

endmodule

[rtl/via_timer_shift_interrupt_core.sv]
// ---------------------------------------------------------------------------
// via_timer_shift_interrupt_core
// Timer, shift register and interrupt core of a versatile interface adapter.
// ---------------------------------------------------------------------------
// Each request transaction is a register read, a register write or one
// peripheral clock tick, and it produces exactly one response transaction
// carrying the read byte (zero for writes and ticks), the IRQ summary and
// the port and control line levels after the request has taken effect.
// The core accepts one request every clock cycle while req_stall is low; a
// request passes an input register, is applied to the register state as it
// advances out of that register, and its response is loaded into the output
// register in the same cycle. A held request waits while a stalled response
// is still in the output register.
module via_timer_shift_interrupt_core import vtsi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  logic      hold_valid;
  req_item_t hold_item;
  logic      advance;
  rsp_item_t result;

  // A held request moves on whenever the response register is free.
  assign advance   = hold_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = hold_valid && !advance;

  vtsi_state u_state (
    .clk    (clk),
    .rst    (rst),
    .apply  (advance),
    .item   (hold_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) hold_item <= req;
    if (advance) rsp <= result;
  end

endmodule
